>>> rtl/core/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg: shared types and constants of the sample history ring
// Sizes, operation codes, controller commands and the result record.
// ----------------------------------------------------------------------------
package shr_pkg;

    localparam int DEPTH       = 256;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int OP_W        = 2;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = SAMPLE_BITS + ADDR_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * SAMPLE_BITS + LEN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_BOUNDS = 2'd3
    } shr_op_t;

    // Where the result fields come from
    typedef enum logic [1:0] {
        SRC_UPDATE = 2'd0,  // state as updated by push or clear this cycle
        SRC_READ   = 2'd1,  // registered memory read of a read op
        SRC_HOLD   = 2'd2   // current registers (after a bounds scan)
    } shr_src_t;

    typedef struct packed {
        logic     cfg_wr;
        logic     push;
        logic     clear;
        logic     rd_issue;
        logic     scan_start;
        logic     scan_step;
        logic     res_valid;
        shr_src_t res_src;
    } shr_cmd_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] read_value;
        logic                   status;
        logic [SAMPLE_BITS-1:0] newest;
        logic [LEN_W-1:0]       stored_count;
        logic [SAMPLE_BITS-1:0] low_bound;
        logic [SAMPLE_BITS-1:0] high_bound;
    } shr_res_t;

endpackage

>>> rtl/core/shr_ctrl.sv
// ----------------------------------------------------------------------------
// shr_ctrl: operation sequencer of the sample history ring
// Decodes each transfer and steps the datapath through reads and scans.
// ----------------------------------------------------------------------------
module shr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  shr_pkg::shr_op_t   op,
    input  logic               cfg_valid,
    input  logic               obuf_full,
    input  logic               scan_last,
    output logic               s_tready,
    output logic               cfg_ready,
    output shr_pkg::shr_cmd_t  cmd
);
    import shr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RD_WAIT = 2'd1,
        ST_SCAN    = 2'd2,
        ST_REPORT  = 2'd3
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Configuration wins over a stream transfer in the same cycle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !obuf_full && !cfg_valid;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        cmd.res_src = SRC_HOLD;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_wr = cfg_valid;
                if (accept)
                begin
                    unique case (op)
                        OP_PUSH:
                        begin
                            cmd.push      = 1'b1;
                            cmd.res_valid = 1'b1;
                            cmd.res_src   = SRC_UPDATE;
                        end
                        OP_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RD_WAIT;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear     = 1'b1;
                            cmd.res_valid = 1'b1;
                            cmd.res_src   = SRC_UPDATE;
                        end
                        OP_BOUNDS:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.res_valid = 1'b1;
                cmd.res_src   = SRC_READ;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                cmd.res_valid = 1'b1;
                cmd.res_src   = SRC_HOLD;
                state_next    = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/shr_dp.sv
// ----------------------------------------------------------------------------
// shr_dp: datapath of the sample history ring
// Sample memory with per-slot valid bits, pointers, bounds and newest value.
// ----------------------------------------------------------------------------
module shr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  shr_pkg::shr_cmd_t                 cmd,
    input  logic [shr_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic [shr_pkg::ADDR_W-1:0]        index,
    input  logic [shr_pkg::LEN_W-1:0]         cfg_len,
    output logic                              scan_last,
    output shr_pkg::shr_res_t                 res
);
    import shr_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] mem_q_reg;
    logic                   vbit_reg;

    logic [DEPTH-1:0]       valid_reg, valid_next;
    logic [ADDR_W-1:0]      wp_reg, wp_next;
    logic [LEN_W-1:0]       held_reg, held_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] newest_reg, newest_next;
    logic                   oor_reg, oor_next;

    logic [LEN_W-1:0]       wp_inc;
    logic [LEN_W-1:0]       held_inc;
    logic [LEN_W-1:0]       rd_sum;
    logic [LEN_W-1:0]       cfg_clamped;
    logic [ADDR_W-1:0]      rd_slot;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] elem;
    logic                   scan_first;

    assign wp_inc   = {1'b0, wp_reg} + LEN_W'(1);
    assign held_inc = (held_reg < len_reg) ? held_reg + LEN_W'(1) : held_reg;
    assign rd_sum   = {1'b0, index} + {1'b0, wp_reg};

    // Logical index to slot: straight while filling, rotated by the pointer once full
    always_comb
    begin
        priority if (held_reg < len_reg)
        begin
            rd_slot = index;
        end
        else if (rd_sum >= len_reg)
        begin
            rd_slot = ADDR_W'(rd_sum - len_reg);
        end
        else
        begin
            rd_slot = rd_sum[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        priority if (cfg_len == '0)
        begin
            cfg_clamped = LEN_W'(1);
        end
        else if (cfg_len > LEN_W'(DEPTH))
        begin
            cfg_clamped = LEN_W'(DEPTH);
        end
        else
        begin
            cfg_clamped = cfg_len;
        end
    end

    always_comb
    begin
        priority if (cmd.rd_issue)
        begin
            rd_addr = rd_slot;
        end
        else if (cmd.scan_step)
        begin
            rd_addr = scan_idx_reg[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Unwritten slots read as zero
    assign elem       = vbit_reg ? mem_q_reg : '0;
    assign scan_first = (scan_idx_reg == LEN_W'(1));
    assign scan_last  = (scan_idx_reg == len_reg);

    always_comb
    begin
        valid_next    = valid_reg;
        wp_next       = wp_reg;
        held_next     = held_reg;
        len_next      = len_reg;
        scan_idx_next = scan_idx_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        newest_next   = newest_reg;
        oor_next      = oor_reg;

        if (cmd.cfg_wr || cmd.clear)
        begin
            valid_next  = '0;
            wp_next     = '0;
            held_next   = '0;
            min_next    = '0;
            max_next    = '0;
            newest_next = '0;
        end
        if (cmd.cfg_wr)
        begin
            len_next = cfg_clamped;
        end
        if (cmd.push)
        begin
            valid_next[wp_reg] = 1'b1;
            wp_next     = (wp_inc >= len_reg) ? '0 : wp_inc[ADDR_W-1:0];
            held_next   = held_inc;
            newest_next = sample;
        end
        if (cmd.rd_issue)
        begin
            oor_next = ({1'b0, index} >= held_reg);
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = LEN_W'(1);
        end
        if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + LEN_W'(1);
            if (scan_first)
            begin
                min_next = elem;
                max_next = elem;
            end
            else
            begin
                if ($signed(elem) < $signed(min_reg))
                begin
                    min_next = elem;
                end
                if ($signed(elem) > $signed(max_reg))
                begin
                    max_next = elem;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wp_reg] <= sample;
        end
        mem_q_reg <= mem[rd_addr];
        vbit_reg  <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            wp_reg       <= '0;
            held_reg     <= '0;
            len_reg      <= LEN_W'(DEPTH);
            scan_idx_reg <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            newest_reg   <= '0;
            oor_reg      <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            wp_reg       <= wp_next;
            held_reg     <= held_next;
            len_reg      <= len_next;
            scan_idx_reg <= scan_idx_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            newest_reg   <= newest_next;
            oor_reg      <= oor_next;
        end
    end

    always_comb
    begin
        res.read_value   = '0;
        res.status       = 1'b0;
        res.newest       = newest_reg;
        res.stored_count = held_reg;
        res.low_bound    = min_reg;
        res.high_bound   = max_reg;
        unique case (cmd.res_src)
            SRC_UPDATE:
            begin
                res.newest       = newest_next;
                res.stored_count = held_next;
                res.low_bound    = min_next;
                res.high_bound   = max_next;
            end
            SRC_READ:
            begin
                res.status     = oor_reg;
                res.read_value = (!oor_reg && vbit_reg) ? mem_q_reg : '0;
            end
            SRC_HOLD:
            begin
                res.read_value = '0;
            end
            default:
            begin
                res.read_value = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) && (len_reg <= LEN_W'(DEPTH)))
        else $error("length in use out of range");

    a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < len_reg)
        else $error("write pointer beyond length in use");

    a_count_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= len_reg)
        else $error("stored count beyond length in use");

    a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg < len_reg) |-> ({1'b0, wp_reg} == held_reg))
        else $error("write pointer does not follow count while filling");
`endif

endmodule

>>> rtl/core/shr_obuf.sv
// ----------------------------------------------------------------------------
// shr_obuf: two-entry result buffer of the sample history ring
// Output register plus skid entry, so a finished result can wait.
// ----------------------------------------------------------------------------
module shr_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  shr_pkg::shr_res_t  res,
    input  logic               m_tready,
    output logic               m_tvalid,
    output shr_pkg::shr_res_t  m_res,
    output logic               full
);
    import shr_pkg::*;

    shr_res_t main_reg, main_next;
    shr_res_t skid_reg, skid_next;
    logic     main_v_reg, main_v_next;
    logic     skid_v_reg, skid_v_next;
    logic     pop;

    assign pop      = main_v_reg && m_tready;
    assign m_tvalid = main_v_reg;
    assign m_res    = main_reg;
    assign full     = skid_v_reg;

    always_comb
    begin
        main_next   = main_reg;
        skid_next   = skid_reg;
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        if (pop)
        begin
            main_next   = skid_reg;
            main_v_next = skid_v_reg;
            skid_v_next = 1'b0;
        end
        if (res_valid)
        begin
            if (!main_v_next)
            begin
                main_next   = res;
                main_v_next = 1'b1;
            end
            else
            begin
                skid_next   = res;
                skid_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

endmodule

>>> rtl/core/sample_history_ring.sv
// ----------------------------------------------------------------------------
// sample_history_ring: ring store of recent Q16.16 samples with min/max scan
// Top level: stream ports, length register port, sequencer, datapath, buffer.
// ----------------------------------------------------------------------------
// The block keeps the most recent samples in a 256-slot ring, of which
// length_in_use slots are used before the write pointer wraps. Each transfer
// in carries an operation on s_tuser: push a sample, read by logical index
// (0 is the oldest), clear, or scan all slots in use for the signed minimum
// and maximum. Every operation returns exactly one result transfer carrying
// the read value (zero unless a read succeeds), an out-of-range flag, the
// newest sample, the stored count and the bounds of the latest scan.
// Push and clear hand their result to the buffer in the cycle they are taken;
// a read waits in ST_RD_WAIT on the registered read of the sample memory;
// a bounds scan steps through the slots in use, one slot per cycle through
// that same read port, then reports. Items are handled one at a time; a
// two-entry result buffer lets the next item enter while a result waits on
// m_tready. Reset and length writes need no clearing pass: each slot has a
// valid bit cleared at once, and a slot never written since reads as zero.
// Write cfg_data only while the block is idle; the written length is taken
// as 1 when zero and as 256 when larger, and the write clears the ring.
// ----------------------------------------------------------------------------
module sample_history_ring (
    input  logic                               clk,
    input  logic                               rst_n,
    // Stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [shr_pkg::IN_DATA_W-1:0]      s_tdata,   // sample[31:0], index[39:32]
    input  logic [shr_pkg::OP_W-1:0]           s_tuser,   // op[1:0]
    // Stream out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [shr_pkg::OUT_DATA_W-1:0]     m_tdata,   // read_value[31:0], newest[63:32],
                                                          // stored_count[72:64],
                                                          // low_bound[104:73],
                                                          // high_bound[136:105], zeros above
    output logic                               m_tuser,   // status[0]
    // Length register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [shr_pkg::LEN_W-1:0]          cfg_data   // length_in_use
);
    import shr_pkg::*;

    shr_cmd_t               cmd;
    shr_res_t               res;
    shr_res_t               m_res;
    shr_op_t                op;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [ADDR_W-1:0]      in_index;
    logic                   obuf_full;
    logic                   scan_last;

    // Unpack the inbound transfer
    assign op        = shr_op_t'(s_tuser);
    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_index  = s_tdata[SAMPLE_BITS +: ADDR_W];

    shr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .op        (op),
        .cfg_valid (cfg_valid),
        .obuf_full (obuf_full),
        .scan_last (scan_last),
        .s_tready  (s_tready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    shr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (in_sample),
        .index     (in_index),
        .cfg_len   (cfg_data),
        .scan_last (scan_last),
        .res       (res)
    );

    shr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (cmd.res_valid),
        .res       (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res),
        .full      (obuf_full)
    );

    // Pack the outbound transfer, lowest field first, zero fill to the byte
    assign m_tdata = {
        (OUT_DATA_W - OUT_FIELDS_W)'(0),
        m_res.high_bound,
        m_res.low_bound,
        m_res.stored_count,
        m_res.newest,
        m_res.read_value
    };
    assign m_tuser = m_res.status;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sample_history_ring
// Streams push, read, clear and bounds operations into the ring under random
// idling and a long output hold-off. Every result transfer is compared field
// by field with a model of the ring that the bench keeps in step with the
// accepted operations. The ring length is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import shr_pkg::*;

    localparam int SB           = SAMPLE_BITS;
    localparam int LW           = LEN_W;
    localparam int CYCLE_LIMIT  = 1000000;  // far above the slowest legal run
    localparam int IDLE_PCT     = 23;
    localparam int HOLD_AT_ITEM = 200;      // hold-off starts once this many are taken
    localparam int HOLD_CYCLES  = 400;
    localparam int SCAN_SLACK   = DEPTH + 40;  // longest op latency with margin

    // One queued operation
    typedef struct {
        shr_op_t         op;
        logic [SB-1:0]   smp;
        logic [ADDR_W-1:0] idx;
    } ring_cmd_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // sample[31:0], index[39:32]
    logic [OP_W-1:0]        s_tuser   = '0;   // op[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // read_value, newest, stored_count,
                                              // low_bound, high_bound, zeros above
    logic                   m_tuser;          // status[0]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LW-1:0]          cfg_data  = '0;   // length_in_use

    // Operations waiting for the driver, and the ring outputs predicted for
    // operations already transferred into the block, oldest first
    ring_cmd_t op_backlog[$];
    shr_res_t  predicted_outputs[$];

    // Bench copy of the ring state
    logic signed [SB-1:0] ring_mem [DEPTH];
    int                   ring_wp;
    int                   ring_count;
    int                   ring_len;
    logic signed [SB-1:0] ring_low;
    logic signed [SB-1:0] ring_high;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  items_taken = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  steady      = 1'b0;   // suppress idling on both sides

    sample_history_ring uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------------

    // Zero the store, the pointer, the count and the bounds
    function automatic void ring_clear();
        for (int i = 0; i < DEPTH; i++)
            ring_mem[i] = '0;
        ring_wp    = 0;
        ring_count = 0;
        ring_low   = '0;
        ring_high  = '0;
    endfunction

    // A written length of zero acts as one, anything above DEPTH as DEPTH
    function automatic int ring_fit_length(logic [LW-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return int'(v);
    endfunction

    function automatic void ring_set_length(logic [LW-1:0] v);
        ring_len = ring_fit_length(v);
        ring_clear();
    endfunction

    // Apply one operation to the model and queue the result it must produce
    function automatic void ring_apply_op(shr_op_t op, logic [SB-1:0] smp,
                                          logic [ADDR_W-1:0] idx);
        shr_res_t r;
        int       slot;
        r = '0;
        case (op)
            OP_PUSH:
            begin
                ring_mem[ring_wp] = smp;
                ring_wp = (ring_wp + 1 >= ring_len) ? 0 : ring_wp + 1;
                if (ring_count < ring_len)
                    ring_count++;
            end
            OP_READ:
            begin
                if (int'(idx) >= ring_count)
                    r.status = 1'b1;
                else
                begin
                    // Before the ring fills, logical order equals slot order;
                    // once full, the oldest sample sits at the write pointer
                    slot = (ring_count < ring_len) ? int'(idx)
                                                   : (int'(idx) + ring_wp) % ring_len;
                    r.read_value = ring_mem[slot];
                end
            end
            OP_CLEAR:
                ring_clear();
            OP_BOUNDS:
            begin
                // Scan every slot in use, unwritten zero slots included
                ring_low  = ring_mem[0];
                ring_high = ring_mem[0];
                for (int i = 1; i < ring_len; i++)
                begin
                    if (ring_mem[i] > ring_high)
                        ring_high = ring_mem[i];
                    if (ring_mem[i] < ring_low)
                        ring_low = ring_mem[i];
                end
            end
        endcase
        r.newest       = (ring_wp == 0) ? ring_mem[ring_len - 1] : ring_mem[ring_wp - 1];
        r.stored_count = LW'(ring_count);
        r.low_bound    = ring_low;
        r.high_bound   = ring_high;
        predicted_outputs.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void queue_op(shr_op_t op, logic [SB-1:0] smp,
                                     logic [ADDR_W-1:0] idx);
        ring_cmd_t c;
        c.op  = op;
        c.smp = smp;
        c.idx = idx;
        op_backlog.push_back(c);
    endfunction

    // Queue n random operations, push-heavy so the ring fills and wraps;
    // reads mostly land near the stored range, the rest anywhere
    function automatic void queue_random(int n, int push_pct, int length);
        int              pick;
        int              read_top;
        logic [SB-1:0]   smp;
        logic [ADDR_W-1:0] idx;
        shr_op_t         op;
        read_top = (length > 255) ? 255 : length;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            smp  = $urandom;
            idx  = ADDR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: smp = 32'h7FFF_FFFF;
                    1: smp = 32'h8000_0000;
                    2: smp = 32'h0000_0000;
                    default: smp = 32'hFFFF_FFFF;
                endcase
            end
            if (pick < push_pct)
                op = OP_PUSH;
            else if (pick < push_pct + (100 - push_pct) * 6 / 10)
            begin
                op = OP_READ;
                if ($urandom_range(0, 3) != 0)
                    idx = ADDR_W'($urandom_range(0, read_top));
            end
            else if (pick < 97)
                op = OP_BOUNDS;
            else
                op = OP_CLEAR;
            queue_op(op, smp, idx);
        end
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Wait until every queued operation went in and every result came back;
    // look just after the edge so the driver's update is already visible
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (op_backlog.size() != 0 || s_tvalid || predicted_outputs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the length register while the block is idle
    task automatic write_length(logic [LW-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ring_set_length(v);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Driver: hold the current transfer until taken, then advance the backlog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        ring_cmd_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            // Predict at the transfer, in the order the block takes items
            if (s_tvalid && s_tready)
            begin
                ring_apply_op(shr_op_t'(s_tuser), s_tdata[0 +: SB], s_tdata[SB +: ADDR_W]);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (op_backlog.size() != 0 && !take_gap())
                begin
                    nxt = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= IN_DATA_W'({nxt.idx, nxt.smp});
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off, during which the
    // sender keeps offering so the result buffer fills and s_tready drops
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT_ITEM)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= !take_gap();
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        shr_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result expected none actual %h status %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                check_field("read_value", 64'(want.read_value), 64'(m_tdata[0 +: SB]));
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("newest", 64'(want.newest), 64'(m_tdata[SB +: SB]));
                check_field("stored_count", 64'(want.stored_count),
                            64'(m_tdata[2*SB +: LW]));
                check_field("low_bound", 64'(want.low_bound), 64'(m_tdata[2*SB+LW +: SB]));
                check_field("high_bound", 64'(want.high_bound),
                            64'(m_tdata[3*SB+LW +: SB]));
                check_field("padding", '0, 64'(m_tdata[OUT_DATA_W-1:OUT_FIELDS_W]));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [LW-1:0] len_list  [9];
        int            item_list [9];
        int            push_list [9];

        ring_len = DEPTH;
        ring_clear();

        // Lengths: one, two, zero (acts as one), all ones (acts as DEPTH),
        // short wrap, mid size, random, above DEPTH, random
        len_list  = '{9'd1, 9'd2, 9'd0, 9'd511, 9'd3, 9'd17, 9'd0, 9'd300, 9'd0};
        len_list[6] = LW'($urandom_range(4, 255));
        len_list[8] = LW'($urandom_range(4, 255));
        item_list = '{50, 50, 30, 300, 60, 100, 70, 60, 60};
        push_list = '{50, 55, 50, 75, 60, 55, 60, 50, 60};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset length: extreme samples, in-range and
        // out-of-range reads, bounds, clear, and reads and bounds after clear
        queue_op(OP_BOUNDS, 32'h0, 8'h0);
        queue_op(OP_READ,   32'h0, 8'h0);
        queue_op(OP_PUSH,   32'h7FFF_FFFF, 8'hFF);
        queue_op(OP_PUSH,   32'h8000_0000, 8'h00);
        queue_op(OP_PUSH,   32'h0000_0000, 8'hFF);
        queue_op(OP_PUSH,   32'hFFFF_FFFF, 8'h00);
        queue_op(OP_PUSH,   32'h0001_0000, 8'h00);
        queue_op(OP_READ,   32'hFFFF_FFFF, 8'd0);
        queue_op(OP_READ,   32'h0, 8'd4);
        queue_op(OP_READ,   32'h0, 8'd5);
        queue_op(OP_READ,   32'h0, 8'd255);
        queue_op(OP_BOUNDS, 32'hFFFF_FFFF, 8'hFF);
        queue_op(OP_CLEAR,  32'h1234_5678, 8'h01);
        queue_op(OP_READ,   32'h0, 8'd0);
        queue_op(OP_BOUNDS, 32'h0, 8'h0);
        queue_op(OP_PUSH,   32'hFFFF_0000, 8'h0);
        queue_op(OP_BOUNDS, 32'h0, 8'h0);
        queue_op(OP_READ,   32'h0, 8'd0);
        wait_drained();

        // Random phases, each behind a length write on an idle block
        for (int p = 0; p < 9; p++)
        begin
            write_length(len_list[p]);
            steady = (p == 5);
            queue_random(item_list[p], push_list[p], ring_fit_length(len_list[p]));
            wait_drained();
        end
        steady = 1'b0;

        // Let any stray result surface before the verdict
        repeat (SCAN_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
